### rtl/core/bis_pkg.sv
// Shared types and constants of the bilinear image sampler.
// Field widths, beat layouts and code types used by the top level.
// No dependencies.
package bis_pkg;

  // Widths of the beat fields.
  localparam int COL_W   = 8;
  localparam int ROW_W   = 8;
  localparam int VALUE_W = 16;
  localparam int COORD_W = 20;
  localparam int OUT_W   = 16;
  localparam int CFG_W   = 9;

  // Layout of in_tdata, lowest field first.
  localparam int COL_LSB   = 0;
  localparam int ROW_LSB   = COL_LSB + COL_W;
  localparam int VALUE_LSB = ROW_LSB + ROW_W;
  localparam int SX_LSB    = VALUE_LSB + VALUE_W;
  localparam int SY_LSB    = SX_LSB + COORD_W;
  localparam int IN_DATA_W = SY_LSB + COORD_W;

  // Kind of an input beat.
  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_SAMPLE = 1'b1
  } op_t;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    CFG_IMAGE_WIDTH  = 1'b0,
    CFG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_t;

endpackage

### rtl/core/bilinear_image_sampler.sv
// Bilinear image sampler with clamp-to-edge addressing over a banked pixel store.
// Top level: pixel store, six-stage sampling pipeline and configuration registers.
// Depends on bis_pkg.
//
//  Channel | Direction | Handshake              | Payload
//  --------+-----------+------------------------+-----------------------------------------
//  in_     | input     | in_tvalid / in_tready  | tuser: op; tdata: col,row,value,x,y
//  out_    | output    | out_tvalid / out_tready| tdata: sample_value
//  cfg_    | input     | cfg_we (no wait)       | cfg_index, cfg_wdata
//
// One beat is taken every cycle while no full stage is stalled. A sample's result moves
// through the stage registers into the output register and waits there until the
// beat is taken. A pixel write passes stage 1 into the store and gives no output beat.
// The one-beat-a-cycle rate is set by the four-bank store: each bank has one read port,
// and the four neighbors of a sample always fall in four different banks (or share an
// entry). Reset clears the stage valid bits and sets the image size to its maximum; the
// pixel store is not cleared. Every stage has its own ready, so a stalled output only
// stops the stages that are full, and bubbles are squeezed out.
module bilinear_image_sampler #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int FRAC_BITS  = 8,
  parameter int PIXEL_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Input channel.
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // Fields from bit 0 up: pixel_column, pixel_row, pixel_value, sample_x, sample_y.
  input  logic [bis_pkg::IN_DATA_W-1:0]       in_tdata,
  // Fields from bit 0 up: operation.
  input  bis_pkg::op_t                        in_tuser,
  // Result channel.
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // Fields from bit 0 up: sample_value.
  output logic [bis_pkg::OUT_W-1:0]           out_tdata,
  // Configuration port.
  input  logic                                cfg_we,
  input  bis_pkg::cfg_reg_t                   cfg_index,
  input  logic [bis_pkg::CFG_W-1:0]           cfg_wdata
);
  import bis_pkg::*;

  // Index widths of the full image and of one bank (a bank holds every second
  // column of every second row).
  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int IW = (CW > RW) ? CW : RW;
  localparam int HC = (CW > 1) ? CW - 1 : 1;
  localparam int HR = (RW > 1) ? RW - 1 : 1;
  localparam int BA = HC + HR;
  localparam int BANK_DEPTH = 1 << BA;
  localparam int NBANK = 4;

  // Size registers are wide enough for the reset value and any written value.
  localparam int SZW_A = $clog2(MAX_WIDTH + 1);
  localparam int SZW_B = $clog2(MAX_HEIGHT + 1);
  localparam int SZW_C = (SZW_A > SZW_B) ? SZW_A : SZW_B;
  localparam int SZW = (SZW_C > CFG_W) ? SZW_C : CFG_W;

  // Signed floor of a coordinate, one bit wider so that floor + 1 never wraps.
  localparam int CB = COORD_W + 1;

  // Arithmetic widths: weights, first products, row sums, second products, total.
  localparam int WTW = FRAC_BITS + 1;
  localparam int MW  = WTW + PIXEL_BITS;
  localparam int TW  = PIXEL_BITS + FRAC_BITS;
  localparam int NW  = WTW + TW;
  localparam int SW  = PIXEL_BITS + 2 * FRAC_BITS;
  localparam logic [WTW-1:0] ONE = WTW'(1) << FRAC_BITS;

  // Saturate a written size into 1..max.
  function automatic logic [SZW-1:0] sat_size(input logic [CFG_W-1:0] v, input int mx);
    logic [SZW-1:0] r;
    if (v == '0) begin
      r = SZW'(1);
    end else if (int'(v) > mx) begin
      r = SZW'(mx);
    end else begin
      r = SZW'(v);
    end
    return r;
  endfunction

  // Clamp a signed neighbor index into 0..size-1.
  function automatic logic [IW-1:0] clamp_idx(input logic signed [CB-1:0] f,
                                              input logic [SZW-1:0] size);
    logic signed [CB-1:0] lim;
    logic [IW-1:0] r;
    lim = signed'(CB'(size));
    if (f < 0) begin
      r = '0;
    end else if (f >= lim) begin
      r = IW'(size - SZW'(1));
    end else begin
      r = IW'(f);
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration registers.
  // ---------------------------------------------------------------------------
  logic [SZW-1:0] width_r, height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= SZW'(MAX_WIDTH);
      height_r <= SZW'(MAX_HEIGHT);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IMAGE_WIDTH:  width_r  <= sat_size(cfg_wdata, MAX_WIDTH);
        CFG_IMAGE_HEIGHT: height_r <= sat_size(cfg_wdata, MAX_HEIGHT);
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Per-stage ready chain. Stage 6 is the output register.
  // ---------------------------------------------------------------------------
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;
  logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;
  op_t  op1_r;

  assign rdy6 = !v6_r || out_tready;
  assign rdy5 = !v5_r || rdy6;
  assign rdy4 = !v4_r || rdy5;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  // A pixel write in stage 1 never waits: it finishes in the store and vanishes.
  assign rdy1 = !v1_r || (op1_r == OP_WRITE) || rdy2;
  assign in_tready = rdy1;

  // ---------------------------------------------------------------------------
  // Stage 1: decode, write range check, floor and clamp of the neighbors.
  // ---------------------------------------------------------------------------
  logic [COL_W-1:0]          in_col;
  logic [ROW_W-1:0]          in_row;
  logic signed [COORD_W-1:0] in_sx, in_sy;
  logic signed [CB-1:0]      fx, fy, fx1, fy1;

  assign in_col = in_tdata[COL_LSB +: COL_W];
  assign in_row = in_tdata[ROW_LSB +: ROW_W];
  assign in_sx  = signed'(in_tdata[SX_LSB +: COORD_W]);
  assign in_sy  = signed'(in_tdata[SY_LSB +: COORD_W]);
  assign fx  = CB'(in_sx >>> FRAC_BITS);
  assign fy  = CB'(in_sy >>> FRAC_BITS);
  assign fx1 = fx + CB'(1);
  assign fy1 = fy + CB'(1);

  logic                  wr_ok1_r;
  logic [CW-1:0]         wcol1_r, x0_1_r, x1_1_r;
  logic [RW-1:0]         wrow1_r, y0_1_r, y1_1_r;
  logic [PIXEL_BITS-1:0] wval1_r;
  logic [FRAC_BITS-1:0]  ax1_r, ay1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (rdy1) begin
      v1_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      op1_r    <= in_tuser;
      wr_ok1_r <= (SZW'(in_col) < width_r) && (SZW'(in_row) < height_r);
      wcol1_r  <= CW'(in_col);
      wrow1_r  <= RW'(in_row);
      wval1_r  <= PIXEL_BITS'(in_tdata[VALUE_LSB +: VALUE_W]);
      x0_1_r   <= CW'(clamp_idx(fx, width_r));
      x1_1_r   <= CW'(clamp_idx(fx1, width_r));
      y0_1_r   <= RW'(clamp_idx(fy, height_r));
      y1_1_r   <= RW'(clamp_idx(fy1, height_r));
      ax1_r    <= in_sx[FRAC_BITS-1:0];
      ay1_r    <= in_sy[FRAC_BITS-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Pixel store: four banks selected by column and row parity. The two columns
  // of a sample differ in parity unless clamping made them equal, so each bank
  // serves at most one of them per cycle; the same holds for rows.
  // ---------------------------------------------------------------------------
  logic [PIXEL_BITS-1:0] mem [NBANK][BANK_DEPTH];
  logic [NBANK-1:0]      bank_we;
  logic [BA-1:0]         waddr;
  logic [BA-1:0]         raddr [NBANK];
  logic [PIXEL_BITS-1:0] rd2_r [NBANK];

  assign waddr = {HR'(wrow1_r >> 1), HC'(wcol1_r >> 1)};
  assign bank_we = (v1_r && (op1_r == OP_WRITE) && wr_ok1_r)
                 ? (NBANK'(1) << {wrow1_r[0], wcol1_r[0]}) : '0;

  always_comb begin
    logic [CW-1:0] rc;
    logic [RW-1:0] rr;
    logic          pc, pr;
    for (int b = 0; b < NBANK; b++) begin
      pc = 1'(b & 1);
      pr = 1'((b >> 1) & 1);
      rc = (x0_1_r[0] == pc) ? x0_1_r : x1_1_r;
      rr = (y0_1_r[0] == pr) ? y0_1_r : y1_1_r;
      raddr[b] = {HR'(rr >> 1), HC'(rc >> 1)};
    end
  end

  always_ff @(posedge clk) begin
    for (int b = 0; b < NBANK; b++) begin
      if (bank_we[b]) begin
        mem[b][waddr] <= wval1_r;
      end
      if (rdy2) begin
        rd2_r[b] <= mem[b][raddr[b]];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: bank read data registered, fractions and parities carried along.
  // ---------------------------------------------------------------------------
  logic [FRAC_BITS-1:0] ax2_r, ay2_r;
  logic                 x0p2_r, x1p2_r, y0p2_r, y1p2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (rdy2) begin
      v2_r <= v1_r && (op1_r == OP_SAMPLE);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      ax2_r  <= ax1_r;
      ay2_r  <= ay1_r;
      x0p2_r <= x0_1_r[0];
      x1p2_r <= x1_1_r[0];
      y0p2_r <= y0_1_r[0];
      y1p2_r <= y1_1_r[0];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: pick the four neighbors out of the banks and weight them in x.
  // ---------------------------------------------------------------------------
  logic [PIXEL_BITS-1:0] p00, p10, p01, p11;
  logic [WTW-1:0]        bx, ax_w;
  logic [MW-1:0]         m00_nxt, m10_nxt, m01_nxt, m11_nxt;
  logic [MW-1:0]         m00_r, m10_r, m01_r, m11_r;
  logic [FRAC_BITS-1:0]  ay3_r;

  assign p00  = rd2_r[{y0p2_r, x0p2_r}];
  assign p10  = rd2_r[{y0p2_r, x1p2_r}];
  assign p01  = rd2_r[{y1p2_r, x0p2_r}];
  assign p11  = rd2_r[{y1p2_r, x1p2_r}];
  assign ax_w = WTW'(ax2_r);
  assign bx   = ONE - ax_w;
  assign m00_nxt = MW'(bx) * MW'(p00);
  assign m10_nxt = MW'(ax_w) * MW'(p10);
  assign m01_nxt = MW'(bx) * MW'(p01);
  assign m11_nxt = MW'(ax_w) * MW'(p11);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (rdy3) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      m00_r <= m00_nxt;
      m10_r <= m10_nxt;
      m01_r <= m01_nxt;
      m11_r <= m11_nxt;
      ay3_r <= ay2_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: row sums. Each stays at most 2^FRAC_BITS times the largest pixel.
  // ---------------------------------------------------------------------------
  logic [TW-1:0]        top_r, bot_r;
  logic [FRAC_BITS-1:0] ay4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (rdy4) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4) begin
      top_r <= TW'(m00_r + m10_r);
      bot_r <= TW'(m01_r + m11_r);
      ay4_r <= ay3_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 5: weight the rows in y.
  // ---------------------------------------------------------------------------
  logic [WTW-1:0] by, ay_w;
  logic [NW-1:0]  n0_r, n1_r;

  assign ay_w = WTW'(ay4_r);
  assign by   = ONE - ay_w;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (rdy5) begin
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy5) begin
      n0_r <= NW'(by) * NW'(top_r);
      n1_r <= NW'(ay_w) * NW'(bot_r);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 6: total, drop the fraction bits (truncating) and hold the result
  // in the output register until the beat is taken.
  // ---------------------------------------------------------------------------
  logic [SW-1:0]         sum;
  logic [PIXEL_BITS-1:0] res;
  logic [OUT_W-1:0]      out_data_nxt, out_data_r;

  assign sum          = SW'(n0_r + n1_r);
  assign res          = PIXEL_BITS'(sum >> (2 * FRAC_BITS));
  assign out_data_nxt = OUT_W'(res);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
    end else if (rdy6) begin
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy6) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = v6_r;
  assign out_tdata  = out_data_r;

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  // The input is only held off by a result that waits at the output.
  a_ready_when_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled while the output register is free");

  // A pixel write goes to at most one bank; a write outside the image goes to none.
  a_one_bank_written: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(bank_we))
    else $error("pixel write hit more than one bank");

  // The image size always stays inside its legal range.
  a_size_range: assert property (@(posedge clk) disable iff (!rst_n)
    (width_r != '0) && (width_r <= SZW'(MAX_WIDTH)) &&
    (height_r != '0) && (height_r <= SZW'(MAX_HEIGHT)))
    else $error("image size register out of range");

endmodule
